// ===== rtl/core/touch_four_corner_calibrator_macros.svh =====
// Assertion macros shared by the calibrator checkers
`ifndef TOUCH_FOUR_CORNER_CALIBRATOR_MACROS_SVH
`define TOUCH_FOUR_CORNER_CALIBRATOR_MACROS_SVH

// same-cycle implication
`define TFCC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfcc check failed");

// next-cycle implication
`define TFCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfcc check failed");

`endif

// ===== rtl/core/tfcc_pkg.sv =====
// Types and constants of the four-corner touch calibrator
package tfcc_pkg;

   localparam int RAW_BITS      = 12;
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int XW            = 9;
   localparam int YW            = 8;
   localparam int STEP_W        = 3;
   localparam int QW            = XW;
   localparam int NUM_W         = RAW_BITS + QW;
   localparam int CNT_W         = $clog2(QW);

   localparam int BTN_W         = 130;
   localparam int BTN_H         = 34;
   localparam int BTN_GAP       = 30;
   localparam int CANCEL_H      = 14;
   localparam int CANCEL_MARGIN = 60;

   typedef logic [RAW_BITS-1:0] raw_type;
   typedef logic [XW-1:0]       sx_type;
   typedef logic [YW-1:0]       sy_type;
   typedef logic [STEP_W-1:0]   step_type;
   typedef logic [QW-1:0]       quo_type;

   localparam logic [1:0] ACT_MAP   = 2'd0;
   localparam logic [1:0] ACT_BEGIN = 2'd1;
   localparam logic [1:0] ACT_TOUCH = 2'd2;

   localparam step_type STEP_START = STEP_W'(0);
   localparam step_type STEP_FIRST = STEP_W'(1);
   localparam step_type STEP_LAST  = STEP_W'(4);

   localparam raw_type CAL_LOW_RST  = RAW_BITS'(150);
   localparam raw_type CAL_HIGH_RST = RAW_BITS'(3900);

   localparam sx_type BTN_X_LO    = XW'((SCREEN_WIDTH - BTN_W) / 2);
   localparam sx_type BTN_X_HI    = XW'((SCREEN_WIDTH - BTN_W) / 2 + BTN_W);
   localparam sy_type BTN_Y_LO    = YW'(SCREEN_HEIGHT - BTN_H - BTN_GAP);
   localparam sy_type BTN_Y_HI    = YW'(SCREEN_HEIGHT - BTN_GAP);
   localparam sx_type CANCEL_X_LO = XW'(CANCEL_MARGIN);
   localparam sx_type CANCEL_X_HI = XW'(SCREEN_WIDTH - CANCEL_MARGIN);
   localparam sy_type CANCEL_Y_LO = YW'(SCREEN_HEIGHT - CANCEL_H);

   localparam quo_type MAX_X = QW'(SCREEN_WIDTH - 1);
   localparam quo_type MAX_Y = QW'(SCREEN_HEIGHT - 1);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

endpackage

// ===== rtl/core/tfcc_if.sv =====
// Request and response channel interfaces of the touch calibrator
interface tfcc_req_if import tfcc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   raw_type    raw_x;
   raw_type    raw_y;
   sx_type     screen_x;
   sy_type     screen_y;

   modport source (output valid, action, raw_x, raw_y, screen_x, screen_y, input ready);
   modport sink   (input valid, action, raw_x, raw_y, screen_x, screen_y, output ready);
endinterface

interface tfcc_rsp_if import tfcc_pkg::*; ();
   logic     valid;
   logic     ready;
   sx_type   mapped_x;
   sy_type   mapped_y;
   logic     session_ended;
   logic     was_cancelled;
   step_type current_step;
   logic     tap_recorded;

   modport source (output valid, mapped_x, mapped_y, session_ended, was_cancelled,
                   current_step, tap_recorded, input ready);
   modport sink   (input valid, mapped_x, mapped_y, session_ended, was_cancelled,
                   current_step, tap_recorded, output ready);
endinterface

// ===== rtl/core/touch_four_corner_calibrator.sv =====
// Four-corner touchscreen calibrator: raw-to-pixel mapping and calibration session
//
// Usage: one request on req_ch (action, raw_x, raw_y, screen_x, screen_y) gives
// exactly one response on rsp_ch. Action 0 maps raw X/Y to clamped pixels, action 1
// restarts the session, action 2 is a session touch (cancel strip, start/next
// button, corner tap capture). After the fourth corner the new bounds are loaded.
// Sequence: a map request runs per axis through a multiply state, a range check,
// the shared restoring divider (one quotient bit per cycle) and a clamp state,
// then through an output state. A raw at or below the low bound or a zero span
// skips the range check and the divider, a quotient above 511 skips the divider
// after the range check. Begin and touch requests go straight to the output
// state, a touch that completes calibration through a bounds averaging state
// first. req_ch.ready is high only while the sequencer is idle, so one request
// is in flight at a time: no new request is taken before the last one has left
// the sequencer for the output register.
// The response sits in an output register; the next request is accepted while it
// waits, and a later response holds in the sequencer until rsp_ch.ready frees
// the output register. Reset (synchronous, active high) returns to the start
// screen, clears the held tap and the cancel flag, and loads bounds 150..3900.
module touch_four_corner_calibrator import tfcc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tfcc_req_if.sink   req_ch,
   tfcc_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_CHECK, ST_DIV, ST_NEXT, ST_LOAD, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      held_ff, held_in;
   logic      cancel_ff, cancel_in;
   logic [2*RAW_BITS-1:0] pair_ff, pair_in;
   logic [2*RAW_BITS-1:0] corner_ff [4];
   logic      corner_we;
   logic [1:0] corner_wa;
   raw_type   xlo_ff, xlo_in, xhi_ff, xhi_in, ylo_ff, ylo_in, yhi_ff, yhi_in;

   raw_type   rawx_ff, rawx_in, rawy_ff, rawy_in;
   logic      axis_ff, axis_in;
   logic [NUM_W-1:0] num_ff, num_in;
   raw_type   span_ff, span_in;
   raw_type   rem_ff, rem_in;
   quo_type   quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   sx_type    mx_ff, mx_in;
   sy_type    my_ff, my_in;
   logic      ended_ff, ended_in;

   logic      rsp_valid_ff, rsp_valid_in;
   sx_type    rsp_mx_ff, rsp_mx_in;
   sy_type    rsp_my_ff, rsp_my_in;
   logic      rsp_ended_ff, rsp_ended_in;
   logic      rsp_cancel_ff, rsp_cancel_in;
   step_type  rsp_step_ff, rsp_step_in;
   logic      rsp_held_ff, rsp_held_in;

   logic      req_fire, in_cancel, in_button;
   raw_type   sel_lo, sel_hi, sel_raw, span, diff;
   quo_type   scale;
   logic [NUM_W-1:0] prod;
   logic [RAW_BITS:0] trial, trial_sub, sum_xl, sum_xh, sum_yl, sum_yh;
   logic      trial_ge;
   raw_type   avg_xl, avg_xh, avg_yl, avg_yh;
   quo_type   clamp_x, clamp_y;

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign req_fire             = req_ch.valid & req_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.mapped_x      = rsp_mx_ff;
   assign rsp_ch.mapped_y      = rsp_my_ff;
   assign rsp_ch.session_ended = rsp_ended_ff;
   assign rsp_ch.was_cancelled = rsp_cancel_ff;
   assign rsp_ch.current_step  = rsp_step_ff;
   assign rsp_ch.tap_recorded  = rsp_held_ff;

   assign in_cancel = (req_ch.screen_y >= CANCEL_Y_LO) && (req_ch.screen_x >= CANCEL_X_LO)
                   && (req_ch.screen_x <= CANCEL_X_HI);
   assign in_button = (req_ch.screen_x >= BTN_X_LO) && (req_ch.screen_x <= BTN_X_HI)
                   && (req_ch.screen_y >= BTN_Y_LO) && (req_ch.screen_y <= BTN_Y_HI);

   // shared datapath: axis operand select, multiplier, divider step
   assign sel_lo  = axis_ff ? ylo_ff : xlo_ff;
   assign sel_hi  = axis_ff ? yhi_ff : xhi_ff;
   assign sel_raw = axis_ff ? rawy_ff : rawx_ff;
   assign scale   = axis_ff ? MAX_Y : MAX_X;
   assign span    = sel_hi - sel_lo;
   assign diff    = sel_raw - sel_lo;
   assign prod    = {{QW{1'b0}}, diff} * {{RAW_BITS{1'b0}}, scale};

   assign trial     = {rem_ff, quo_ff[QW-1]};
   assign trial_ge  = trial >= {1'b0, span_ff};
   assign trial_sub = trial - {1'b0, span_ff};

   assign clamp_x = (quo_ff > MAX_X) ? MAX_X : quo_ff;
   assign clamp_y = (quo_ff > MAX_Y) ? MAX_Y : quo_ff;

   // bounds from corners: TL=0, TR=1, BR=2, BL=3; X low bits, Y high bits
   assign sum_xl = {1'b0, corner_ff[0][RAW_BITS-1:0]} + {1'b0, corner_ff[3][RAW_BITS-1:0]};
   assign sum_xh = {1'b0, corner_ff[1][RAW_BITS-1:0]} + {1'b0, corner_ff[2][RAW_BITS-1:0]};
   assign sum_yl = {1'b0, corner_ff[0][2*RAW_BITS-1:RAW_BITS]}
                 + {1'b0, corner_ff[1][2*RAW_BITS-1:RAW_BITS]};
   assign sum_yh = {1'b0, corner_ff[3][2*RAW_BITS-1:RAW_BITS]}
                 + {1'b0, corner_ff[2][2*RAW_BITS-1:RAW_BITS]};
   assign avg_xl = sum_xl[RAW_BITS:1];
   assign avg_xh = sum_xh[RAW_BITS:1];
   assign avg_yl = sum_yl[RAW_BITS:1];
   assign avg_yh = sum_yh[RAW_BITS:1];

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      held_in       = held_ff;
      cancel_in     = cancel_ff;
      pair_in       = pair_ff;
      corner_we     = 1'b0;
      corner_wa     = 2'(step_ff - STEP_FIRST);
      xlo_in        = xlo_ff;
      xhi_in        = xhi_ff;
      ylo_in        = ylo_ff;
      yhi_in        = yhi_ff;
      rawx_in       = rawx_ff;
      rawy_in       = rawy_ff;
      axis_in       = axis_ff;
      num_in        = num_ff;
      span_in       = span_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      ended_in      = ended_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_mx_in     = rsp_mx_ff;
      rsp_my_in     = rsp_my_ff;
      rsp_ended_in  = rsp_ended_ff;
      rsp_cancel_in = rsp_cancel_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_held_in   = rsp_held_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rawx_in  = req_ch.raw_x;
               rawy_in  = req_ch.raw_y;
               ended_in = 1'b0;
               mx_in    = '0;
               my_in    = '0;
               state_in = ST_FINISH;
               case (req_ch.action)
                  ACT_MAP: begin
                     axis_in  = 1'b0;
                     state_in = ST_MUL;
                  end
                  ACT_BEGIN: begin
                     step_in   = STEP_START;
                     held_in   = 1'b0;
                     cancel_in = 1'b0;
                  end
                  ACT_TOUCH: begin
                     cancel_in = 1'b0;
                     if (in_cancel) begin
                        cancel_in = 1'b1;
                        ended_in  = 1'b1;
                     end else if (step_ff == STEP_START) begin
                        if (in_button) begin
                           step_in = STEP_FIRST;
                           held_in = 1'b0;
                        end
                     end else if (held_ff && in_button) begin
                        corner_we = 1'b1;
                        if (step_ff == STEP_LAST) begin
                           step_in  = STEP_START;
                           ended_in = 1'b1;
                           state_in = ST_LOAD;
                        end else begin
                           step_in = step_ff + STEP_FIRST;
                           held_in = 1'b0;
                        end
                     end else begin
                        pair_in = {req_ch.raw_y, req_ch.raw_x};
                        held_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            xlo_in   = (avg_xl > avg_xh) ? avg_xh : avg_xl;
            xhi_in   = (avg_xl > avg_xh) ? avg_xl : avg_xh;
            ylo_in   = (avg_yl > avg_yh) ? avg_yh : avg_yl;
            yhi_in   = (avg_yl > avg_yh) ? avg_yl : avg_yh;
            state_in = ST_FINISH;
         end
         ST_MUL: begin
            if ((sel_raw <= sel_lo) || (span == '0)) begin
               quo_in   = '0;
               state_in = ST_NEXT;
            end else begin
               num_in   = prod;
               span_in  = span;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (num_ff[NUM_W-1:QW] >= span_ff) begin
               quo_in   = '1;
               state_in = ST_NEXT;
            end else begin
               rem_in   = num_ff[NUM_W-1:QW];
               quo_in   = num_ff[QW-1:0];
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[RAW_BITS-1:0] : trial[RAW_BITS-1:0];
            quo_in = {quo_ff[QW-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (!axis_ff) begin
               mx_in    = clamp_x;
               axis_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               my_in    = YW'(clamp_y);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mx_in     = mx_ff;
               rsp_my_in     = my_ff;
               rsp_ended_in  = ended_ff;
               rsp_cancel_in = cancel_ff;
               rsp_step_in   = step_ff;
               rsp_held_in   = held_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rawx_ff       <= rawx_in;
      rawy_ff       <= rawy_in;
      axis_ff       <= axis_in;
      num_ff        <= num_in;
      span_ff       <= span_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      mx_ff         <= mx_in;
      my_ff         <= my_in;
      ended_ff      <= ended_in;
      rsp_mx_ff     <= rsp_mx_in;
      rsp_my_ff     <= rsp_my_in;
      rsp_ended_ff  <= rsp_ended_in;
      rsp_cancel_ff <= rsp_cancel_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_held_ff   <= rsp_held_in;
      if (corner_we) begin
         corner_ff[corner_wa] <= pair_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_START;
         held_ff      <= 1'b0;
         cancel_ff    <= 1'b0;
         pair_ff      <= '0;
         xlo_ff       <= CAL_LOW_RST;
         xhi_ff       <= CAL_HIGH_RST;
         ylo_ff       <= CAL_LOW_RST;
         yhi_ff       <= CAL_HIGH_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         held_ff      <= held_in;
         cancel_ff    <= cancel_in;
         pair_ff      <= pair_in;
         xlo_ff       <= xlo_in;
         xhi_ff       <= xhi_in;
         ylo_ff       <= ylo_in;
         yhi_ff       <= yhi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/tfcc_checker.sv =====
// Port-level checks of the touch calibrator and their bind
`include "touch_four_corner_calibrator_macros.svh"

module tfcc_checker import tfcc_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input sx_type   mapped_x,
   input sy_type   mapped_y,
   input logic     session_ended,
   input logic     was_cancelled,
   input step_type current_step
);

   `TFCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TFCC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `TFCC_ASSERT_SAME(a_step_range, clock, reset, rsp_valid, current_step <= STEP_LAST)
   `TFCC_ASSERT_SAME(a_save_to_start, clock, reset, rsp_valid && session_ended && !was_cancelled, current_step == STEP_START)
   `TFCC_ASSERT_SAME(a_pixel_range, clock, reset, rsp_valid, (9'(mapped_x) <= MAX_X) && (9'(mapped_y) <= MAX_Y))

endmodule

bind touch_four_corner_calibrator tfcc_checker u_tfcc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .mapped_x      (rsp_ch.mapped_x),
   .mapped_y      (rsp_ch.mapped_y),
   .session_ended (rsp_ch.session_ended),
   .was_cancelled (rsp_ch.was_cancelled),
   .current_step  (rsp_ch.current_step)
);

// ===== tb/tb_touch_four_corner_calibrator.sv =====
`timescale 1ns / 100ps
// Testbench for the touch calibrator: directed request table, then random sessions vs a predictor
module tb_touch_four_corner_calibrator import tfcc_pkg::*; ();

   localparam logic [1:0] ACT_NOP = 2'd3;
   localparam int RAND_ITEMS   = 1700;
   localparam int IDLE_PCT     = 16;
   localparam int CALM_LO      = 700;
   localparam int CALM_HI      = 1000;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int PAUSE_AT     = 1200;
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_REPORTS  = 100;
   localparam int RUN_LIMIT_NS = 8_000_000;

   typedef struct packed {
      sx_type   mapped_x;
      sy_type   mapped_y;
      logic     session_ended;
      logic     was_cancelled;
      step_type current_step;
      logic     tap_recorded;
   } calib_rsp_type;

   typedef struct packed {
      raw_type y;
      raw_type x;
   } raw_pair_type;

   typedef struct {
      logic [1:0]    action;
      raw_type       raw_x;
      raw_type       raw_y;
      sx_type        screen_x;
      sy_type        screen_y;
      bit            known;
      calib_rsp_type known_rsp;
   } touch_req_type;

   logic clock = 1'b0;
   logic reset;

   tfcc_req_if req_ch ();
   tfcc_rsp_if rsp_ch ();

   touch_four_corner_calibrator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   step_type     step_q      = STEP_START;
   bit           held_q      = 1'b0;
   bit           cancel_q    = 1'b0;
   raw_pair_type held_pair_q = '0;
   raw_pair_type corner_q [4];
   raw_type      x_lo_q      = CAL_LOW_RST;
   raw_type      x_hi_q      = CAL_HIGH_RST;
   raw_type      y_lo_q      = CAL_LOW_RST;
   raw_type      y_hi_q      = CAL_HIGH_RST;

   touch_req_type touch_req_q [$];
   calib_rsp_type calib_expect_q [$];
   int            err_count = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("Regression FAIL");
      $finish;
   end

   function automatic bit in_cancel(sx_type sx, sy_type sy);
      return sy >= CANCEL_Y_LO && sx >= CANCEL_X_LO && sx <= CANCEL_X_HI;
   endfunction

   function automatic bit in_button(sx_type sx, sy_type sy);
      return sx >= BTN_X_LO && sx <= BTN_X_HI && sy >= BTN_Y_LO && sy <= BTN_Y_HI;
   endfunction

   function automatic logic [8:0] scale_axis(raw_type raw, raw_type lo, raw_type hi, int size);
      longint span;
      longint v;
      span = longint'(hi) - longint'(lo);
      v = 0;
      if (span != 0) v = (longint'(raw) - longint'(lo)) * longint'(size - 1) / span;
      if (v < 0) v = 0;
      if (v > size - 1) v = size - 1;
      return 9'(v);
   endfunction

   function automatic calib_rsp_type predict_calib(touch_req_type r);
      calib_rsp_type o;
      logic [12:0] xl, xh, yl, yh;
      o = '0;
      case (r.action)
         ACT_MAP: begin
            o.mapped_x = scale_axis(r.raw_x, x_lo_q, x_hi_q, SCREEN_WIDTH);
            o.mapped_y = 8'(scale_axis(r.raw_y, y_lo_q, y_hi_q, SCREEN_HEIGHT));
         end
         ACT_BEGIN: begin
            step_q   = STEP_START;
            held_q   = 1'b0;
            cancel_q = 1'b0;
         end
         ACT_TOUCH: begin
            cancel_q = 1'b0;
            if (in_cancel(r.screen_x, r.screen_y)) begin
               cancel_q = 1'b1;
               o.session_ended = 1'b1;
            end else if (step_q == STEP_START) begin
               if (in_button(r.screen_x, r.screen_y)) begin
                  step_q = STEP_FIRST;
                  held_q = 1'b0;
               end
            end else if (held_q && in_button(r.screen_x, r.screen_y)) begin
               corner_q[2'(step_q - STEP_FIRST)] = held_pair_q;
               if (step_q == STEP_LAST) begin
                  // left edge TL/BL, right edge TR/BR, top TL/TR, bottom BL/BR
                  xl = ({1'b0, corner_q[0].x} + {1'b0, corner_q[3].x}) >> 1;
                  xh = ({1'b0, corner_q[1].x} + {1'b0, corner_q[2].x}) >> 1;
                  yl = ({1'b0, corner_q[0].y} + {1'b0, corner_q[1].y}) >> 1;
                  yh = ({1'b0, corner_q[3].y} + {1'b0, corner_q[2].y}) >> 1;
                  x_lo_q = (xl > xh) ? xh[11:0] : xl[11:0];
                  x_hi_q = (xl > xh) ? xl[11:0] : xh[11:0];
                  y_lo_q = (yl > yh) ? yh[11:0] : yl[11:0];
                  y_hi_q = (yl > yh) ? yl[11:0] : yh[11:0];
                  step_q = STEP_START;
                  o.session_ended = 1'b1;
               end else begin
                  step_q = step_q + 1'b1;
                  held_q = 1'b0;
               end
            end else begin
               held_pair_q = {r.raw_y, r.raw_x};
               held_q      = 1'b1;
            end
         end
         default: ;
      endcase
      o.was_cancelled = cancel_q;
      o.current_step  = step_q;
      o.tap_recorded  = held_q;
      return o;
   endfunction

   function automatic void add_req(logic [1:0] act, int rx, int ry, int sx, int sy);
      touch_req_type r;
      r.action    = act;
      r.raw_x     = raw_type'(rx);
      r.raw_y     = raw_type'(ry);
      r.screen_x  = sx_type'(sx);
      r.screen_y  = sy_type'(sy);
      r.known     = 1'b0;
      r.known_rsp = '0;
      touch_req_q.push_back(r);
   endfunction

   function automatic void add_known(logic [1:0] act, int rx, int ry, int sx, int sy,
                                     int mx, int my, bit ended, bit canc, int step, bit tap);
      int last;
      add_req(act, rx, ry, sx, sy);
      last = touch_req_q.size() - 1;
      touch_req_q[last].known     = 1'b1;
      touch_req_q[last].known_rsp = {sx_type'(mx), sy_type'(my), ended, canc,
                                     step_type'(step), tap};
   endfunction

   function automatic int edge_raw();
      int k;
      k = $urandom_range(9, 0);
      if (k == 0) return 0;
      if (k == 1) return 4095;
      return $urandom_range(4095, 0);
   endfunction

   function automatic void add_map();
      add_req(ACT_MAP, edge_raw(), edge_raw(), $urandom_range(SCREEN_WIDTH - 1, 0),
              $urandom_range(SCREEN_HEIGHT - 1, 0));
   endfunction

   function automatic void add_button();
      add_req(ACT_TOUCH, edge_raw(), edge_raw(), $urandom_range(BTN_X_HI, BTN_X_LO),
              $urandom_range(BTN_Y_HI, BTN_Y_LO));
   endfunction

   function automatic void add_cancel();
      add_req(ACT_TOUCH, edge_raw(), edge_raw(), $urandom_range(CANCEL_X_HI, CANCEL_X_LO),
              $urandom_range(SCREEN_HEIGHT - 1, CANCEL_Y_LO));
   endfunction

   function automatic void add_tap(raw_pair_type p);
      int sx, sy;
      do begin
         sx = $urandom_range(SCREEN_WIDTH - 1, 0);
         sy = $urandom_range(SCREEN_HEIGHT - 1, 0);
      end while (in_button(sx_type'(sx), sy_type'(sy)) || in_cancel(sx_type'(sx), sy_type'(sy)));
      add_req(ACT_TOUCH, p.x, p.y, sx, sy);
   endfunction

   // mode 0-4 plausible corners, 5-6 mirrored panel, 7-8 anything, 9 all corners equal
   function automatic raw_pair_type corner_raw(int c, int mode, raw_pair_type fixed);
      raw_pair_type p;
      bit left, top;
      left = (c == 0 || c == 3);
      top  = (c < 2);
      if (mode == 5 || mode == 6) begin
         left = !left;
         top  = !top;
      end
      if (mode == 9) return fixed;
      if (mode >= 7) begin
         p.x = raw_type'($urandom_range(4095, 0));
         p.y = raw_type'($urandom_range(4095, 0));
         return p;
      end
      p.x = raw_type'(left ? $urandom_range(700, 0) : $urandom_range(4095, 3400));
      p.y = raw_type'(top ? $urandom_range(700, 0) : $urandom_range(4095, 3400));
      return p;
   endfunction

   function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         if (err_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         err_count++;
      end
   endfunction

   initial begin : drive_requests
      int i, c, k, mode, n_dir;
      raw_pair_type fixed;
      touch_req_type r;
      calib_rsp_type e;

      req_ch.valid    <= 1'b0;
      req_ch.action   <= ACT_MAP;
      req_ch.raw_x    <= '0;
      req_ch.raw_y    <= '0;
      req_ch.screen_x <= '0;
      req_ch.screen_y <= '0;

      add_known(ACT_MAP, 0, 0, 0, 0, 0, 0, 0, 0, STEP_START, 0);
      add_known(ACT_MAP, 4095, 4095, 0, 0, MAX_X, MAX_Y, 0, 0, STEP_START, 0);
      add_known(ACT_MAP, 150, 3900, 0, 0, 0, MAX_Y, 0, 0, STEP_START, 0);
      add_req(ACT_MAP, 2025, 1000, 0, 0);
      add_known(ACT_NOP, 4095, 4095, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1,
                0, 0, 0, 0, STEP_START, 0);
      add_known(ACT_TOUCH, 0, 4095, CANCEL_X_LO, CANCEL_Y_LO, 0, 0, 1, 1, STEP_START, 0);
      add_known(ACT_TOUCH, 4095, 0, CANCEL_X_HI, SCREEN_HEIGHT - 1,
                0, 0, 1, 1, STEP_START, 0);
      add_known(ACT_TOUCH, 4095, 4095, BTN_X_LO, BTN_Y_LO, 0, 0, 0, 0, STEP_FIRST, 0);
      add_req(ACT_TOUCH, 1000, 1000, 0, 0);
      add_req(ACT_TOUCH, 4095, 4095, BTN_X_HI, BTN_Y_HI);
      // cancel mid-session keeps the step
      add_known(ACT_TOUCH, 0, 0, 150, 230, 0, 0, 1, 1, STEP_FIRST + 1, 0);
      // button with no tap held records the tap
      add_req(ACT_TOUCH, 1000, 1000, 160, 190);
      add_req(ACT_TOUCH, 4095, 4095, 160, 190);
      add_req(ACT_TOUCH, 1000, 1000, 0, SCREEN_HEIGHT - 1);
      add_req(ACT_TOUCH, 0, 0, BTN_X_LO, BTN_Y_HI);
      add_req(ACT_TOUCH, 1000, 1000, SCREEN_WIDTH - 1, CANCEL_Y_LO - 1);
      add_req(ACT_TOUCH, 0, 4095, BTN_X_HI, BTN_Y_LO);
      // all corners equal: zero span maps to 0
      add_known(ACT_MAP, 4095, 0, 0, 0, 0, 0, 0, 0, STEP_START, 1);
      add_known(ACT_MAP, 0, 4095, 0, 0, 0, 0, 0, 0, STEP_START, 1);
      add_known(ACT_NOP, 0, 0, 0, 0, 0, 0, 0, 0, STEP_START, 1);
      add_known(ACT_BEGIN, 4095, 4095, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1,
                0, 0, 0, 0, STEP_START, 0);
      n_dir = touch_req_q.size();

      while (touch_req_q.size() < n_dir + RAND_ITEMS) begin
         k = $urandom_range(99, 0);
         if (k < 60) begin
            mode     = $urandom_range(9, 0);
            fixed.x  = raw_type'($urandom_range(4095, 0));
            fixed.y  = raw_type'($urandom_range(4095, 0));
            add_req(ACT_BEGIN, edge_raw(), edge_raw(), 0, 0);
            add_button();
            for (c = 0; c < 4; c++) begin
               if ($urandom_range(19, 0) == 0) break;
               repeat ($urandom_range(3, 1)) add_tap(corner_raw(c, mode, fixed));
               if ($urandom_range(9, 0) == 0) add_cancel();
               add_button();
            end
            repeat ($urandom_range(6, 1)) add_map();
         end else if (k < 75) begin
            repeat ($urandom_range(8, 1)) add_map();
         end else if (k < 88) begin
            add_req(ACT_TOUCH, edge_raw(), edge_raw(), $urandom_range(SCREEN_WIDTH - 1, 0),
                    $urandom_range(SCREEN_HEIGHT - 1, 0));
         end else if (k < 93) begin
            add_req(ACT_BEGIN, edge_raw(), edge_raw(), $urandom_range(SCREEN_WIDTH - 1, 0),
                    $urandom_range(SCREEN_HEIGHT - 1, 0));
         end else if (k < 97) begin
            add_cancel();
         end else begin
            add_req(ACT_NOP, edge_raw(), edge_raw(), $urandom_range(SCREEN_WIDTH - 1, 0),
                    $urandom_range(SCREEN_HEIGHT - 1, 0));
         end
      end

      do @(posedge clock); while (reset);

      for (i = 0; i < touch_req_q.size(); i++) begin
         r = touch_req_q[i];
         if (i == PAUSE_AT) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (calib_expect_q.size() != 0);
         end else if ((i < CALM_LO || i >= CALM_HI) && $urandom_range(99, 0) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99, 0) < IDLE_PCT);
         end
         req_ch.valid    <= 1'b1;
         req_ch.action   <= r.action;
         req_ch.raw_x    <= r.raw_x;
         req_ch.raw_y    <= r.raw_y;
         req_ch.screen_x <= r.screen_x;
         req_ch.screen_y <= r.screen_y;
         do @(posedge clock); while (!req_ch.ready);
         e = predict_calib(r);
         calib_expect_q.push_back(r.known ? r.known_rsp : e);
      end
      req_ch.valid <= 1'b0;

      while (calib_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : sink_responses
      int hold_left, rsp_count;
      bit hold_done;
      calib_rsp_type want, got;

      hold_left = 0;
      rsp_count = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.mapped_x, rsp_ch.mapped_y, rsp_ch.session_ended,
                   rsp_ch.was_cancelled, rsp_ch.current_step, rsp_ch.tap_recorded};
            if (calib_expect_q.size() == 0) begin
               if (err_count < MAX_REPORTS)
                  $display("%0t: unexpected response, expected none, actual %h", $time, got);
               err_count++;
            end else begin
               want = calib_expect_q.pop_front();
               check_field("mapped_x", want.mapped_x, got.mapped_x);
               check_field("mapped_y", want.mapped_y, got.mapped_y);
               check_field("session_ended", want.session_ended, got.session_ended);
               check_field("was_cancelled", want.was_cancelled, got.was_cancelled);
               check_field("current_step", want.current_step, got.current_step);
               check_field("tap_recorded", want.tap_recorded, got.tap_recorded);
            end
            rsp_count++;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            // long back-pressure so the block fills and stalls its request side
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (rsp_count >= CALM_LO && rsp_count < CALM_HI) ||
                            ($urandom_range(99, 0) >= IDLE_PCT);
         end
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tfcc_pkg.sv
rtl/core/tfcc_if.sv
rtl/core/touch_four_corner_calibrator.sv
rtl/core/tfcc_checker.sv
tb/tb_touch_four_corner_calibrator.sv
